[src/hgm_pkg.sv]
// Package for the heightmap grid mesh generator: sizes, widths, types.
`default_nettype none
package hgm_pkg;
    // Largest heightmap, in pixels per row and rows
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_ROWS   = 1024;
    // Column and row counter widths
    localparam int PXW = $clog2(MAX_WIDTH);
    localparam int PYW = $clog2(MAX_ROWS);
    // Size register width, grid coordinate width
    localparam int SZW = 11;
    // Divider: dividend and quotient widths
    localparam int DVW = 28;
    localparam int QW  = 16;
    localparam int CFG_IDXW = 8;

    // Configuration register indexes
    localparam logic [CFG_IDXW-1:0] REG_IMAGE_WIDTH  = CFG_IDXW'(0);
    localparam logic [CFG_IDXW-1:0] REG_IMAGE_HEIGHT = CFG_IDXW'(1);

    // Division operations done for each vertex
    typedef enum logic [1:0] {
        OP_POS_X = 2'd0,
        OP_TEX_U = 2'd1,
        OP_POS_Z = 2'd2,
        OP_TEX_V = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SETUP,
        S_LOAD,
        S_DIV,
        S_OUT,
        S_FIN
    } t_state;
endpackage
`default_nettype wire

[src/hgm_if.sv]
// Handshake interfaces: pixel words, vertex words and register writes.
`default_nettype none
interface hgm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface hgm_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vertex_x;
    logic [7:0]         vertex_height;
    logic signed [15:0] vertex_z;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic               last_in_run;
    logic               mesh_done;
    modport source (output valid, vertex_x, vertex_height, vertex_z, tex_u, tex_v,
                    last_in_run, mesh_done, input ready);
    modport sink (input valid, vertex_x, vertex_height, vertex_z, tex_u, tex_v,
                  last_in_run, mesh_done, output ready);
endinterface

interface hgm_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/heightmap_grid_mesh_generator.sv]
// Heightmap grid mesh generator: pixels in raster order to triangle vertices.
`default_nettype none
// Takes one RGB pixel per word in raster order and emits the grid cells it
// completes as two triangles (six vertices each, up to four cells per pixel).
// Positions and texture coordinates come from one shared restoring divider
// that retires one quotient bit per cycle; each vertex needs four divisions of
// 16 bits, each a load followed by the divider steps, and then waits in its
// output state until the vertex is taken. One pixel is worked on at a time; the
// pixel port is not ready until every vertex of the current pixel has been
// taken. A write to either size register restarts the image at its first
// pixel. The previous row lives in a single-port line store read at the
// current column and written at the end of each pixel.
module heightmap_grid_mesh_generator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hgm_pix_if.sink   i_pix,
    hgm_vtx_if.source o_vtx,
    hgm_cfg_if.sink   i_cfg
);
    import hgm_pkg::*;

    t_state r_state, n_state;

    logic [SZW-1:0] r_width, r_height;
    logic [PXW-1:0] r_col, r_px;
    logic [PYW-1:0] r_row, r_py;
    logic [7:0]     r_gray, r_cur_left, r_above_left, r_mem_q;
    logic [7:0]     mem [MAX_WIDTH];

    logic [SZW-1:0] r_xlo, r_xhi, r_yhi, r_x, r_y;
    logic [2:0]     r_k;
    t_op            r_op;
    logic           r_last_pix;

    logic [SZW:0]   r_rem;
    logic [QW-1:0]  r_dvd, r_quo;
    logic [SZW-1:0] r_dvs;
    logic [3:0]     r_step;

    logic signed [15:0] r_vx, r_vz;
    logic [14:0]        r_tu, r_tv;
    logic [7:0]         r_vh;

    // Effective sizes and grid sizes
    logic [SZW-1:0] w_eff, h_eff, gc, gr;
    always_comb begin
        if (r_width == '0) w_eff = SZW'(1);
        else if (r_width > SZW'(MAX_WIDTH)) w_eff = SZW'(MAX_WIDTH);
        else w_eff = r_width;
        if (r_height == '0) h_eff = SZW'(1);
        else if (r_height > SZW'(MAX_ROWS)) h_eff = SZW'(MAX_ROWS);
        else h_eff = r_height;
        gc = (w_eff < SZW'(2)) ? SZW'(2) : w_eff;
        gr = (h_eff < SZW'(2)) ? SZW'(2) : h_eff;
    end

    // Gray conversion
    logic [12:0] gray_sum;
    assign gray_sum = 13'(i_pix.red) * 13'd11 + {1'b0, i_pix.green, 4'b0}
                    + 13'(i_pix.blue) * 13'd5;

    wire pix_acc = i_pix.valid && i_pix.ready;
    wire vtx_acc = o_vtx.valid && o_vtx.ready;
    wire cfg_acc = i_cfg.valid && i_cfg.ready;

    // Cell ranges of the current pixel
    logic [SZW-1:0] px_w, py_w, xlo, xhi, ylo, yhi;
    logic           xany, yany;
    always_comb begin
        px_w = SZW'(r_px);
        py_w = SZW'(r_py);
        xany = 1'b1;
        yany = 1'b1;
        if (px_w == w_eff - SZW'(1)) begin
            xlo = (w_eff >= SZW'(2)) ? w_eff - SZW'(2) : '0;
            xhi = gc - SZW'(1);
        end else if (px_w != '0) begin
            xlo = px_w - SZW'(1);
            xhi = px_w - SZW'(1);
        end else begin
            xany = 1'b0;
            xlo = '0;
            xhi = '0;
        end
        if (py_w == h_eff - SZW'(1)) begin
            ylo = (h_eff >= SZW'(2)) ? h_eff - SZW'(2) : '0;
            yhi = gr - SZW'(1);
        end else if (py_w != '0) begin
            ylo = py_w - SZW'(1);
            yhi = py_w - SZW'(1);
        end else begin
            yany = 1'b0;
            ylo = '0;
            yhi = '0;
        end
    end

    // Corner of the current vertex
    logic [SZW-1:0] cx, cy, ex, ey;
    logic [7:0]     corner_h;
    always_comb begin
        cx = r_x;
        cy = r_y;
        case (r_k) inside
            3'd2, 3'd3, 3'd4: cx = r_x + SZW'(1);
            default: cx = r_x;
        endcase
        case (r_k) inside
            3'd1, 3'd2, 3'd3: cy = r_y + SZW'(1);
            default: cy = r_y;
        endcase
        ex = (cx > w_eff - SZW'(1)) ? w_eff - SZW'(1) : cx;
        ey = (cy > h_eff - SZW'(1)) ? h_eff - SZW'(1) : cy;
        if (ey == py_w) corner_h = (ex == px_w) ? r_gray : r_cur_left;
        else corner_h = (ex == px_w) ? r_mem_q : r_above_left;
    end

    // Divider operands for the current operation
    logic [SZW-1:0] op_c, op_n, op_cl;
    logic [DVW-1:0] op_dvd;
    always_comb begin
        op_c = (r_op == OP_POS_Z || r_op == OP_TEX_V) ? cy : cx;
        op_n = (r_op == OP_POS_Z || r_op == OP_TEX_V) ? gr : gc;
        op_cl = (op_c > op_n - SZW'(1)) ? op_n - SZW'(1) : op_c;
        if (r_op == OP_TEX_U || r_op == OP_TEX_V) op_dvd = {3'b0, op_c, 1'b1, 13'b0};
        else op_dvd = {1'b0, op_cl, 16'b0};
    end

    // One restoring divider step
    logic [SZW:0] div_t, div_r;
    logic         div_ge;
    always_comb begin
        div_t  = {r_rem[SZW-1:0], r_dvd[QW-1]};
        div_ge = div_t >= {1'b0, r_dvs};
        div_r  = div_ge ? div_t - {1'b0, r_dvs} : div_t;
    end
    logic [QW-1:0] quo_n;
    assign quo_n = {r_quo[QW-2:0], div_ge};

    wire last_vtx = (r_k == 3'd5) && (r_x == r_xhi) && (r_y == r_yhi);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (pix_acc) n_state = S_READ;
            S_READ:  n_state = S_SETUP;
            S_SETUP: n_state = (xany && yany) ? S_LOAD : S_FIN;
            S_LOAD:  n_state = S_DIV;
            S_DIV: begin
                if (r_step == '0) n_state = (r_op == OP_TEX_V) ? S_OUT : S_LOAD;
            end
            S_OUT: begin
                if (vtx_acc) n_state = last_vtx ? S_FIN : S_LOAD;
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_pix.ready = (r_state == S_IDLE);
        o_vtx.valid = (r_state == S_OUT);
        i_cfg.ready = 1'b1;
    end

    assign o_vtx.vertex_x      = r_vx;
    assign o_vtx.vertex_height = r_vh;
    assign o_vtx.vertex_z      = r_vz;
    assign o_vtx.tex_u         = r_tu;
    assign o_vtx.tex_v         = r_tv;
    assign o_vtx.last_in_run   = last_vtx;
    assign o_vtx.mesh_done     = last_vtx && r_last_pix;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_width      <= SZW'(256);
            r_height     <= SZW'(256);
            r_col        <= '0;
            r_row        <= '0;
            r_cur_left   <= '0;
            r_above_left <= '0;
            r_k          <= '0;
            r_op         <= OP_POS_X;
        end else begin
            r_state <= n_state;
            if (cfg_acc && (i_cfg.index == REG_IMAGE_WIDTH ||
                            i_cfg.index == REG_IMAGE_HEIGHT)) begin
                if (i_cfg.index == REG_IMAGE_WIDTH) r_width <= i_cfg.data;
                else r_height <= i_cfg.data;
                r_col <= '0;
                r_row <= '0;
            end
            if (r_state == S_SETUP) begin
                r_k  <= '0;
                r_op <= OP_POS_X;
            end
            if (r_state == S_DIV && r_step == '0) r_op <= t_op'(r_op + 2'd1);
            if (r_state == S_OUT && vtx_acc) begin
                r_k <= (r_k == 3'd5) ? 3'd0 : r_k + 3'd1;
            end
            if (r_state == S_FIN) begin
                r_above_left <= r_mem_q;
                r_cur_left   <= r_gray;
                if (SZW'(r_px) == w_eff - SZW'(1)) begin
                    r_col <= '0;
                    r_row <= (SZW'(r_py) == h_eff - SZW'(1)) ? '0 : r_py + PYW'(1);
                end else begin
                    r_col <= r_px + PXW'(1);
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_gray     <= gray_sum[12:5];
            r_px       <= r_col;
            r_py       <= r_row;
            r_last_pix <= (SZW'(r_col) == w_eff - SZW'(1)) &&
                          (SZW'(r_row) == h_eff - SZW'(1));
        end
        if (r_state == S_SETUP) begin
            r_xlo <= xlo;
            r_xhi <= xhi;
            r_yhi <= yhi;
            r_x   <= xlo;
            r_y   <= ylo;
        end
        if (r_state == S_OUT && vtx_acc && r_k == 3'd5) begin
            if (r_x == r_xhi) begin
                r_x <= r_xlo;
                r_y <= r_y + SZW'(1);
            end else begin
                r_x <= r_x + SZW'(1);
            end
        end
        if (r_state == S_LOAD) begin
            r_rem  <= op_dvd[DVW-1:QW];
            r_dvd  <= op_dvd[QW-1:0];
            r_dvs  <= op_n;
            r_quo  <= '0;
            r_step <= 4'hF;
            if (r_op == OP_POS_X) r_vh <= corner_h;
        end
        if (r_state == S_DIV) begin
            r_rem  <= div_r;
            r_dvd  <= {r_dvd[QW-2:0], 1'b0};
            r_quo  <= quo_n;
            r_step <= r_step - 4'd1;
            if (r_step == '0) begin
                case (r_op)
                    OP_POS_X: r_vx <= $signed({~quo_n[15], quo_n[14:0]});
                    OP_TEX_U: r_tu <= quo_n[14:0];
                    OP_POS_Z: r_vz <= $signed({~quo_n[15], quo_n[14:0]});
                    OP_TEX_V: r_tv <= quo_n[14:0];
                    default:  r_tv <= quo_n[14:0];
                endcase
            end
        end
    end

    // Line store of the previous row
    always_ff @(posedge i_clk) begin
        r_mem_q <= mem[r_px];
        if (r_state == S_FIN) mem[r_px] <= r_gray;
    end

    // Checks
    a_busy_no_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vtx.valid |-> !i_pix.ready)
        else $error("pixel port ready while a vertex is pending");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.mesh_done) |-> o_vtx.last_in_run)
        else $error("mesh end flagged off the last vertex of a pixel");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (SZW'(r_col) < w_eff))
        else $error("column counter beyond image width");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_DIV && r_step == 4'hF))
        else $error("divider not started after load");
endmodule
`default_nettype wire

[test/heightmap_grid_mesh_generator_test.sv]
// Testbench for the heightmap grid mesh generator: table, extremes, random images.
`timescale 1ns / 1ps
module heightmap_grid_mesh_generator_test;
    import hgm_pkg::*;

    // One expected vertex word
    typedef struct {
        logic signed [15:0] vx;
        logic [7:0]         vh;
        logic signed [15:0] vz;
        logic [14:0]        tu;
        logic [14:0]        tv;
        logic               last;
        logic               done;
    } t_vertex;

    // Directed row: a register write or a pixel with an optional typed height
    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;
    typedef struct {
        t_row_kind   kind;
        logic [7:0]  idx;
        logic [10:0] data;
        logic [7:0]  r, g, b;
        int          height;  // -1 when only the predictor says what comes
    } t_row;

    localparam int SETTLE_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hgm_pix_if pix ();
    hgm_vtx_if vtx ();
    hgm_cfg_if cfg ();

    heightmap_grid_mesh_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .o_vtx   (vtx.source),
        .i_cfg   (cfg.sink)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state
    logic [10:0] mdl_width = 11'd256;
    logic [10:0] mdl_height = 11'd256;
    logic [7:0]  line_buf [MAX_WIDTH];
    logic [7:0]  up_left = '0;
    logic [7:0]  cur_left = '0;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    t_vertex vertex_q[$];
    int errors = 0;
    int pixels_sent = 0;
    int vertices_seen = 0;
    int cfg_writes = 0;
    int images_done = 0;
    int burst_left = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [15:0] pos_q15(input int unsigned c, input int unsigned n);
        int unsigned cl;
        longint v;
        cl = (c > n - 1) ? n - 1 : c;
        v = longint'((64'd65536 * cl) / n) - 32768;
        return v[15:0];
    endfunction

    function automatic logic [14:0] tex_q14(input int unsigned c, input int unsigned n);
        longint unsigned v;
        v = (64'd16384 * (2 * c + 1)) / (2 * n);
        return v[14:0];
    endfunction

    // Range of cells that a pixel at position p finishes along one axis
    task automatic cells_done(input int unsigned p, input int unsigned size,
                              input int unsigned grid, output int unsigned lo,
                              output int unsigned hi, output bit any);
        any = 1;
        lo = 0;
        hi = 0;
        if (p == size - 1) begin
            lo = (size >= 2) ? size - 2 : 0;
            hi = grid - 1;
        end else if (p >= 1) begin
            lo = p - 1;
            hi = p - 1;
        end else begin
            any = 0;
        end
    endtask

    // Expected vertices for one accepted pixel; typed_h overrides the heights
    task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input int typed_h);
        int unsigned w, h, gc, gr, px, py, xlo, xhi, ylo, yhi, cx, cy, ex, ey, n;
        logic [7:0] gray, above;
        bit xany, yany, last_px;
        t_vertex v;
        w = eff_size(mdl_width, MAX_WIDTH);
        h = eff_size(mdl_height, MAX_ROWS);
        gc = (w < 2) ? 2 : w;
        gr = (h < 2) ? 2 : h;
        gray = 8'((11 * int'(r) + 16 * int'(g) + 5 * int'(b)) >> 5);
        n = 0;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        px = col_pos;
        py = row_pos;
        above = line_buf[px];
        last_px = (px == w - 1) && (py == h - 1);
        cells_done(px, w, gc, xlo, xhi, xany);
        cells_done(py, h, gr, ylo, yhi, yany);
        if (xany && yany) begin
            for (int unsigned y = ylo; y <= yhi; y++) begin
                for (int unsigned x = xlo; x <= xhi; x++) begin
                    // Corners 00,01,11,11,10,00
                    for (int k = 0; k < 6; k++) begin
                        cx = x + ((k >= 2 && k <= 4) ? 1 : 0);
                        cy = y + ((k >= 1 && k <= 3) ? 1 : 0);
                        ex = (cx > w - 1) ? w - 1 : cx;
                        ey = (cy > h - 1) ? h - 1 : cy;
                        if (ey == py) v.vh = (ex == px) ? gray : cur_left;
                        else v.vh = (ex == px) ? above : up_left;
                        if (typed_h >= 0) v.vh = 8'(typed_h);
                        v.vx = pos_q15(cx, gc);
                        v.vz = pos_q15(cy, gr);
                        v.tu = tex_q14(cx, gc);
                        v.tv = tex_q14(cy, gr);
                        v.last = 1'b0;
                        v.done = 1'b0;
                        vertex_q.push_back(v);
                        n++;
                    end
                end
            end
            vertex_q[$].last = 1'b1;
            if (last_px) begin
                vertex_q[$].done = 1'b1;
                images_done++;
            end
        end
        up_left = above;
        line_buf[px] = gray;
        cur_left = gray;
        col_pos = px + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = py + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic wait_idle();
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // End the current pixel burst so no stale word stays offered
    task automatic stop_burst();
        if (burst_left != 0) pix.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Register write, only while the block has nothing left to deliver
    task automatic write_reg(input logic [7:0] idx, input logic [10:0] data);
        stop_burst();
        wait_idle();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        cfg_writes++;
        if (idx == REG_IMAGE_WIDTH) mdl_width = data;
        else if (idx == REG_IMAGE_HEIGHT) mdl_height = data;
        if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    // Pixel word, sent in bursts with random gaps between them
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input int typed_h);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        pix.valid <= 1'b1;
        pix.red <= r;
        pix.green <= g;
        pix.blue <= b;
        do @(posedge i_clk); while (!pix.ready);
        predict_pixel(r, g, b, typed_h);
        pixels_sent++;
        if (burst_left == 0) pix.valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        logic [7:0] r, g, b;
        for (int i = 0; i < count; i++) begin
            r = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
            g = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
            b = 8'($urandom);
            send_pixel(r, g, b, -1);
        end
    endtask

    // Receiver: check each taken vertex, then pick the next ready level
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_vertex e;
        if (!i_rst_n) begin
            vtx.ready <= 1'b0;
        end else begin
            if (vtx.valid && vtx.ready) begin
                vertices_seen++;
                if (vertex_q.size() == 0) begin
                    report("vertex word with nothing expected");
                end else begin
                    e = vertex_q.pop_front();
                    if (vtx.vertex_x !== e.vx)
                        report($sformatf("vertex_x %0d want %0d", vtx.vertex_x, e.vx));
                    if (vtx.vertex_height !== e.vh)
                        report($sformatf("height %0d want %0d", vtx.vertex_height, e.vh));
                    if (vtx.vertex_z !== e.vz)
                        report($sformatf("vertex_z %0d want %0d", vtx.vertex_z, e.vz));
                    if (vtx.tex_u !== e.tu)
                        report($sformatf("tex_u %0d want %0d", vtx.tex_u, e.tu));
                    if (vtx.tex_v !== e.tv)
                        report($sformatf("tex_v %0d want %0d", vtx.tex_v, e.tv));
                    if (vtx.last_in_run !== e.last)
                        report($sformatf("last_in_run %b want %b", vtx.last_in_run, e.last));
                    if (vtx.mesh_done !== e.done)
                        report($sformatf("mesh_done %b want %b", vtx.mesh_done, e.done));
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(16, 128);
            end
            stall_left--;
            case (stall_mode)
                0: vtx.ready <= 1'b1;
                1: vtx.ready <= 1'($urandom);
                default: vtx.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Directed table
    t_row rows[$];
    function automatic t_row cfg_row(input logic [7:0] idx, input logic [10:0] data);
        t_row t;
        t = '{ROW_CFG, idx, data, 8'h0, 8'h0, 8'h0, -1};
        return t;
    endfunction
    function automatic t_row pix_row(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input int height);
        t_row t;
        t = '{ROW_PIX, 8'h0, 11'h0, r, g, b, height};
        return t;
    endfunction

    initial begin
        int unsigned w, h;
        int cnt;
        for (int i = 0; i < MAX_WIDTH; i++) line_buf[i] = '0;
        pix.valid = 1'b0;
        pix.red = '0;
        pix.green = '0;
        pix.blue = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        vtx.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 1x1 image: every corner is the pixel itself, so heights are its gray
        rows.push_back(cfg_row(REG_IMAGE_WIDTH, 11'd1));
        rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 11'd1));
        rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 255));
        rows.push_back(pix_row(8'h00, 8'h00, 8'h00, 0));
        rows.push_back(pix_row(8'hFF, 8'h00, 8'h00, 87));
        rows.push_back(pix_row(8'h00, 8'hFF, 8'h00, 127));
        rows.push_back(pix_row(8'h00, 8'h00, 8'hFF, 39));
        // Sizes out of range: zero acts as one, too large acts as the maximum
        rows.push_back(cfg_row(REG_IMAGE_WIDTH, 11'd0));
        rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 11'h7FF));
        rows.push_back(pix_row(8'h12, 8'h34, 8'h56, -1));
        rows.push_back(pix_row(8'hA5, 8'h5A, 8'hC3, -1));
        rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, -1));
        // Unknown register index is ignored and keeps the position
        rows.push_back(cfg_row(8'hFE, 11'h7FF));
        rows.push_back(pix_row(8'h01, 8'h80, 8'h7F, -1));
        // 3x2 image, then wrap into the next image
        rows.push_back(cfg_row(REG_IMAGE_WIDTH, 11'd3));
        rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 11'd2));
        for (int i = 0; i < 8; i++)
            rows.push_back(pix_row(8'(i * 37), 8'(255 - i * 29), 8'(i * 91), -1));
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
            else send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].height);
        end

        // Widest row, one row high: every pixel after the first closes a cell
        write_reg(REG_IMAGE_WIDTH, 11'd1024);
        write_reg(REG_IMAGE_HEIGHT, 11'd1);
        send_random(8);

        // Random images, mostly small, each run past its end now and then
        for (int phase = 0; pixels_sent < 120; phase++) begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            if ($urandom_range(0, 1)) begin
                write_reg(REG_IMAGE_WIDTH, 11'(w));
                write_reg(REG_IMAGE_HEIGHT, 11'(h));
            end else begin
                write_reg(REG_IMAGE_HEIGHT, 11'(h));
                write_reg(REG_IMAGE_WIDTH, 11'(w));
            end
            w = eff_size(11'(w), MAX_WIDTH);
            h = eff_size(11'(h), MAX_ROWS);
            if (phase == 2) begin
                send_random(w);
                stop_burst();
                while (vertex_q.size() != 0) @(posedge i_clk);
            end
            cnt = $urandom_range(1, 2 * w * h + 1);
            if (cnt > 130 - pixels_sent) cnt = 130 - pixels_sent;
            send_random(cnt);
        end

        // End of stimulus: drain and settle
        stop_burst();
        wait_idle();
        $display("Covered %0d pixels, %0d vertices, %0d register writes, %0d full meshes.",
                 pixels_sent, vertices_seen, cfg_writes, images_done);
        if (errors == 0 && vertex_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d vertices still expected", errors, vertex_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50ms;
        $display("Timeout with %0d vertices still expected", vertex_q.size());
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
